FILE: hdl/tga_pkg.sv
// Shared widths, constants and series coefficients of the trigamma unit.
// No dependencies; tga_horner, trigamma_approx_unit and tga_port_check use this package.
package tga_pkg;

    localparam int ARG_W      = 24;   // argument, unsigned Q8.16
    localparam int OUT_W      = 32;   // result, unsigned Q16.16
    localparam int D_W        = 25;   // shifted argument a + j * 2^16
    localparam int SQ_W       = 2 * D_W;
    localparam int RQ_W       = 46;   // reciprocal-square quotient bits
    localparam int DIV_W      = SQ_W + RQ_W;
    localparam int P_W        = 25;   // p = 1/y^2 in Q30 stays below 2^25
    localparam int HP_W       = 25;
    localparam int T_W        = 33;   // signed Horner accumulator
    localparam int Q_W        = 29;   // quotient of the division by y
    localparam int NUM2_W     = D_W + Q_W;
    localparam int SUM_W      = 48;
    localparam int RES_W      = SUM_W - 14;
    localparam int FRAC_DROP  = 14;
    localparam int RECIP_EXP  = 62;
    localparam int SHIFT_STEPS = 6;
    localparam int ONE_Q16    = 65536;
    localparam int TINY_LIMIT = 256;
    localparam int HORNER_STEPS = 5;

    localparam logic signed [T_W-1:0] COEF_5_66 = 33'sd81344078;
    localparam logic signed [T_W-1:0] COEF_1_30 = 33'sd35791394;
    localparam logic signed [T_W-1:0] COEF_1_42 = 33'sd25565282;
    localparam logic signed [T_W-1:0] COEF_1_6  = 33'sd178956971;
    localparam logic signed [T_W-1:0] COEF_ONE  = 33'sd1073741824;

    // Added after each Horner multiply, signs of the series folded in.
    localparam logic signed [T_W-1:0] HORNER_COEF [HORNER_STEPS] = '{
        -COEF_1_30, COEF_1_42, -COEF_1_30, COEF_1_6, COEF_ONE
    };

    typedef logic [RQ_W-1:0] recip_t;
    typedef logic signed [T_W-1:0] acc_t;

endpackage

FILE: hdl/tga_delay.sv
// Shift line with a common advance enable, used to keep side data aligned.
// Depends on nothing; widths and depth come from the instantiating module.
module tga_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

FILE: hdl/tga_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the caller guarantees num < den * 2^QW.
module tga_div #(
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DW+QW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic [QW-1:0]    quo
);

    localparam int W = DW + QW;

    logic [W-1:0]  rem_reg [QW-1];
    logic [DW-1:0] den_reg [QW-1];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BIT = QW - 1 - k;
        logic [W-1:0]  rem_in;
        logic [W-1:0]  rem_next;
        logic [W-1:0]  shifted;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = W'(den_in) << BIT;

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= shifted)
            begin
                rem_next      = rem_in - shifted;
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QW - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

FILE: hdl/tga_horner.sv
// One Horner step t' = round(t * p) + c over two register stages.
// Depends on tga_pkg for the accumulator and p widths.
module tga_horner (
    input  logic                      clk,
    input  logic                      en,
    input  tga_pkg::acc_t             t_in,
    input  logic [tga_pkg::P_W-1:0]   p_in,
    input  tga_pkg::acc_t             coef,
    output tga_pkg::acc_t             t_out,
    output logic [tga_pkg::P_W-1:0]   p_out
);

    import tga_pkg::*;

    localparam int PROD_W = T_W + P_W;
    localparam int R_W    = PROD_W - 30;

    logic              neg_next;
    logic [T_W-1:0]    mag;
    logic [PROD_W-1:0] prod_next;
    logic              neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [P_W-1:0]    p_a_reg;
    logic [PROD_W-1:0] prod_rnd;
    acc_t              r_s;
    acc_t              t_next;
    acc_t              t_reg;
    logic [P_W-1:0]    p_b_reg;

    // The product is rounded on its magnitude, so halves go away from zero.
    assign neg_next  = t_in[T_W-1];
    assign mag       = neg_next ? T_W'(-t_in) : T_W'(t_in);
    assign prod_next = PROD_W'(mag) * PROD_W'(p_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg  <= neg_next;
            prod_reg <= prod_next;
            p_a_reg  <= p_in;
        end
    end

    assign prod_rnd = prod_reg + (PROD_W'(1) << 29);
    assign r_s      = T_W'(prod_rnd[PROD_W-1:30]);
    assign t_next   = (neg_reg ? -r_s : r_s) + coef;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_next;
            p_b_reg <= p_a_reg;
        end
    end

    assign t_out = t_reg;
    assign p_out = p_b_reg;

endmodule

FILE: hdl/trigamma_approx_unit.sv
// Top level of the trigamma unit: argument shift, reciprocal squares,
// Horner series, division by y and final sum. Uses tga_pkg, tga_delay,
// tga_div and tga_horner.
//
//   channel   direction   handshake              payload
//   argument  in          arg_valid / arg_stall  arg_x
//   result    out         res_valid / res_stall  trigamma_value, saturated
//
// One argument is taken per cycle while arg_stall is low; each result passes
// the 46-stage reciprocal dividers, the ten Horner stages and the 29-stage
// division by y. Reset clears only the three delay lines, valid bits among them.
// The whole pipeline advances together; it holds while a result waits
// with res_stall high, and arg_stall follows that condition.
module trigamma_approx_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        arg_valid,
    output logic                        arg_stall,
    input  logic [tga_pkg::ARG_W-1:0]   arg_x,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [tga_pkg::OUT_W-1:0]   trigamma_value,
    output logic                        saturated
);

    import tga_pkg::*;

    localparam int NTERM   = SHIFT_STEPS + 1;
    localparam int LAT     = 93;
    localparam int D6_DLY  = 58;
    localparam int SIDE_DLY = 40;
    localparam int SIDE_W  = SHIFT_STEPS * RQ_W + HP_W;

    logic en;
    logic tiny;
    logic [1:0] ctrl_out;

    logic [D_W-1:0]    d_reg   [NTERM];
    logic [SQ_W-1:0]   sq_reg  [NTERM];
    logic [DIV_W-1:0]  num_reg [NTERM];
    logic [SQ_W-1:0]   den_reg [NTERM];
    recip_t            recip   [NTERM];

    assign en        = !(res_valid && res_stall);
    assign arg_stall = !en;
    assign tiny      = arg_x <= ARG_W'(TINY_LIMIT);

    tga_delay #(.W(2), .DEPTH(LAT)) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  ({tiny, arg_valid}),
        .dout (ctrl_out)
    );

    assign res_valid = ctrl_out[0];

    // Term j divides 2^62 by (a + j)^2; the last term gives p from y = x + 6.
    for (genvar j = 0; j < NTERM; j++)
    begin : g_term
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[j]   <= D_W'(arg_x) + D_W'(j * ONE_Q16);
                sq_reg[j]  <= SQ_W'(d_reg[j]) * SQ_W'(d_reg[j]);
                num_reg[j] <= (DIV_W'(1) << RECIP_EXP) + DIV_W'(sq_reg[j] >> 1);
                den_reg[j] <= sq_reg[j];
            end
        end

        tga_div #(.DW(SQ_W), .QW(RQ_W)) u_recip (
            .clk(clk),
            .en (en),
            .num(num_reg[j]),
            .den(den_reg[j]),
            .quo(recip[j])
        );
    end

    // Horner series in p.
    acc_t           t_chain [HORNER_STEPS+1];
    logic [P_W-1:0] p_chain [HORNER_STEPS+1];

    assign t_chain[0] = COEF_5_66;
    assign p_chain[0] = recip[SHIFT_STEPS][P_W-1:0];

    for (genvar h = 0; h < HORNER_STEPS; h++)
    begin : g_horner
        tga_horner u_step (
            .clk  (clk),
            .en   (en),
            .t_in (t_chain[h]),
            .p_in (p_chain[h]),
            .coef (HORNER_COEF[h]),
            .t_out(t_chain[h+1]),
            .p_out(p_chain[h+1])
        );
    end

    logic [D_W-1:0] d6_dly;

    tga_delay #(.W(D_W), .DEPTH(D6_DLY)) u_d6 (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (d_reg[SHIFT_STEPS]),
        .dout (d6_dly)
    );

    // A negative series value is clamped to zero before the division by y.
    logic [T_W-1:0]    t_pos;
    logic [NUM2_W-1:0] num2_reg;
    logic [D_W-1:0]    den2_reg;
    logic [Q_W-1:0]    q_val;

    assign t_pos = t_chain[HORNER_STEPS][T_W-1] ? '0 : T_W'(t_chain[HORNER_STEPS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num2_reg <= (NUM2_W'(t_pos) << 16) + NUM2_W'(d6_dly >> 1);
            den2_reg <= d6_dly;
        end
    end

    tga_div #(.DW(D_W), .QW(Q_W)) u_div_y (
        .clk(clk),
        .en (en),
        .num(num2_reg),
        .den(den2_reg),
        .quo(q_val)
    );

    // Recurrence terms and p/2 wait for the series result.
    logic [HP_W-1:0]   half_p;
    logic [SIDE_W-1:0] side_in;
    logic [SIDE_W-1:0] side_out;

    assign half_p  = HP_W'((HP_W'(recip[SHIFT_STEPS][P_W-1:0]) + HP_W'(1)) >> 1);
    assign side_in = {recip[5], recip[4], recip[3], recip[2], recip[1], recip[0], half_p};

    tga_delay #(.W(SIDE_W), .DEPTH(SIDE_DLY)) u_side (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .din  (side_in),
        .dout (side_out)
    );

    logic [SUM_W-1:0] r_term [SHIFT_STEPS];
    logic [SUM_W-1:0] hp_term;

    for (genvar j = 0; j < SHIFT_STEPS; j++)
    begin : g_unpack
        assign r_term[j] = SUM_W'(side_out[HP_W + j*RQ_W +: RQ_W]);
    end
    assign hp_term = SUM_W'(side_out[HP_W-1:0]);

    logic [SUM_W-1:0] a_reg [4];
    logic [SUM_W-1:0] b_reg [2];
    logic [SUM_W-1:0] sum_reg;
    logic [RES_W-1:0] res;
    logic [OUT_W-1:0] res_reg;
    logic             ovf_reg;

    assign res = RES_W'((sum_reg + (SUM_W'(1) << (FRAC_DROP - 1))) >> FRAC_DROP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= SUM_W'(q_val) + hp_term;
            a_reg[1] <= r_term[0] + r_term[1];
            a_reg[2] <= r_term[2] + r_term[3];
            a_reg[3] <= r_term[4] + r_term[5];
            b_reg[0] <= a_reg[0] + a_reg[1];
            b_reg[1] <= a_reg[2] + a_reg[3];
            sum_reg  <= b_reg[0] + b_reg[1];
            res_reg  <= res[OUT_W-1:0];
            ovf_reg  <= res[RES_W-1:OUT_W] != '0;
        end
    end

    assign saturated      = ovf_reg || ctrl_out[1];
    assign trigamma_value = saturated ? '1 : res_reg;

endmodule

FILE: hdl/tga_port_check.sv
// Port-level checks of the trigamma unit and the bind that attaches them.
// Depends on tga_pkg for the port widths.
module tga_port_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        arg_valid,
    input logic                        arg_stall,
    input logic [tga_pkg::ARG_W-1:0]   arg_x,
    input logic                        res_valid,
    input logic                        res_stall,
    input logic [tga_pkg::OUT_W-1:0]   trigamma_value,
    input logic                        saturated
);

    // A waiting result keeps its value.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(trigamma_value)
                                   && $stable(saturated))
        else $error("result changed while stalled");

    // The argument side holds exactly when a result waits.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        arg_stall == (res_valid && res_stall))
        else $error("argument stall does not follow result stall");

    // A clamped result always reads as full scale.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && saturated |-> trigamma_value == '1)
        else $error("saturated result is not full scale");

endmodule

bind trigamma_approx_unit tga_port_check u_port_check (.*);
